/* rtl/msc_pkg.sv */
// Shared constants, types and codes for the matrix symmetry classifier.
package msc_pkg;

    localparam int MAX_DIM     = 16;
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int ADDR_W      = 2 * IDX_W;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int ELEM_W      = 32;
    localparam int SIZE_W      = 5;
    localparam int CLASS_W     = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // position of an element relative to the diagonal
    localparam logic [1:0] KIND_LOWER = 2'd0;
    localparam logic [1:0] KIND_DIAG  = 2'd1;
    localparam logic [1:0] KIND_UPPER = 2'd2;

    localparam logic [CLASS_W-1:0] CLASS_SYM  = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_SKEW = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_NONE = 2'd2;

    typedef struct packed {
        logic [ELEM_W-1:0] value;
        logic [ELEM_W-1:0] other;
        logic [1:0]        kind;
        logic              last;
    } msc_entry_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } msc_qstat_t;

endpackage

/* rtl/msc_elem_if.sv */
// Valid/ready channel carrying one matrix element per transaction.
interface msc_elem_if;
    import msc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

/* rtl/msc_class_if.sv */
// Valid/ready channel carrying one matrix class per transaction.
interface msc_class_if;
    import msc_pkg::*;

    logic               valid;
    logic               ready;
    logic [CLASS_W-1:0] matrix_class;

    modport source (output valid, output matrix_class, input ready);
    modport sink   (input valid, input matrix_class, output ready);
endinterface

/* rtl/msc_front.sv */
// Front end: element intake, position tracking, element store and transpose lookup.
module msc_front
    import msc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    msc_elem_if.sink          elem,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,
    input  msc_qstat_t        qstat,
    output logic              push,
    output msc_entry_t        entry
);

    logic [SIZE_W-1:0] size_reg;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  col_reg, col_next;
    logic [DIM_W-1:0]  dim;
    logic [IDX_W-1:0]  last_idx;
    logic              accept;
    logic              row_end, mat_end;

    logic              stage_valid_reg;
    logic [ELEM_W-1:0] value_reg;
    logic [1:0]        kind_reg, kind_next;
    logic              last_reg;
    logic [ELEM_W-1:0] rd_data_reg;

    logic [ELEM_W-1:0] store [0:STORE_DEPTH-1];

    // size 0 acts as 1, sizes above MAX_DIM saturate
    always_comb
    begin
        if (size_reg == '0)
            dim = DIM_W'(1);
        else if (int'(size_reg) > MAX_DIM)
            dim = DIM_W'(MAX_DIM);
        else
            dim = DIM_W'(size_reg);
    end

    assign last_idx = IDX_W'(dim - DIM_W'(1));

    // credit check: queue entries plus the one in the lookup stage
    assign elem.ready = (QCNT_W'(qstat.count) + QCNT_W'(stage_valid_reg))
                        < QCNT_W'(QUEUE_DEPTH);
    assign accept = elem.valid && elem.ready;

    assign row_end = (col_reg == last_idx);
    assign mat_end = row_end && (row_reg == last_idx);

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (!row_end)
        begin
            col_next = col_reg + IDX_W'(1);
        end
        else if (!mat_end)
        begin
            col_next = '0;
            row_next = row_reg + IDX_W'(1);
        end
        else
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_comb
    begin
        if (col_reg < row_reg)
            kind_next = KIND_LOWER;
        else if (col_reg == row_reg)
            kind_next = KIND_DIAG;
        else
            kind_next = KIND_UPPER;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg        <= SIZE_W'(4);
            row_reg         <= '0;
            col_reg         <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= accept;
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
                row_reg  <= '0;
                col_reg  <= '0;
            end
            else if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= elem.element_value;
            kind_reg  <= kind_next;
            last_reg  <= mat_end;
        end
    end

    // element (i,j) at {i,j}; lookup of (j,i) lands with the stage register
    always_ff @(posedge clk)
    begin
        if (accept)
            store[{row_reg, col_reg}] <= elem.element_value;
        rd_data_reg <= store[{col_reg, row_reg}];
    end

    assign push        = stage_valid_reg;
    assign entry.value = value_reg;
    assign entry.other = rd_data_reg;
    assign entry.kind  = kind_reg;
    assign entry.last  = last_reg;

endmodule

/* rtl/msc_queue.sv */
// Small FIFO between the front end and the back end.
module msc_queue
    import msc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  msc_entry_t push_entry,
    input  logic       pop,
    output msc_entry_t head,
    output msc_qstat_t qstat
);

    msc_entry_t        slots [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_entry;
    end

    assign head        = slots[rd_ptr_reg];
    assign qstat.count = count_reg;
    assign qstat.empty = (count_reg == '0);

endmodule

/* rtl/msc_back.sv */
// Back end: pairwise compare, running flags and the class output register.
module msc_back
    import msc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  msc_qstat_t qstat,
    input  msc_entry_t head,
    output logic       pop,
    msc_class_if.source result
);

    logic               sym_reg, sym_next;
    logic               skew_reg, skew_next;
    logic               out_valid_reg;
    logic [CLASS_W-1:0] class_reg, class_next;
    logic               blocked;

    // only the final element of a matrix needs a free output register
    assign blocked = head.last && out_valid_reg && !result.ready;
    assign pop     = !qstat.empty && !blocked;

    always_comb
    begin
        sym_next  = sym_reg;
        skew_next = skew_reg;
        case (head.kind)
            KIND_LOWER:
            begin
                if (head.value != head.other)
                    sym_next = 1'b0;
                if (head.value != (ELEM_W'(0) - head.other))
                    skew_next = 1'b0;
            end
            KIND_DIAG:
            begin
                if (head.value != '0)
                    skew_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        if (sym_next)
            class_next = CLASS_SYM;
        else if (skew_next)
            class_next = CLASS_SKEW;
        else
            class_next = CLASS_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_reg       <= 1'b1;
            skew_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                sym_reg  <= 1'b1;
                skew_reg <= 1'b1;
            end
            else if (pop)
            begin
                sym_reg  <= head.last ? 1'b1 : sym_next;
                skew_reg <= head.last ? 1'b1 : skew_next;
            end

            if (pop && head.last)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.last)
            class_reg <= class_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.matrix_class = class_reg;

endmodule

/* rtl/matrix_symmetry_classifier.sv */
// Top level: matrix symmetry classifier, front end, queue and back end.
//
//   channel   dir  handshake      payload
//   elem      in   valid/ready    element_value [31:0] signed
//   result    out  valid/ready    matrix_class  [1:0]
//   cfg       in   cfg_we         cfg_wdata     [4:0]  (matrix_size)
//
// One element per cycle while credits remain; the element store has one
// write and one read port, and the transpose lookup is one registered read.
// A class is registered when the final element is popped from the queue.
// Reset clears counters, flags and queue; the element store is not cleared.
// A stalled result stalls only the final element; the 4-entry queue absorbs
// the rest, and the front end stops taking elements once its credits run out.
module matrix_symmetry_classifier
    import msc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    msc_elem_if.sink          elem,
    msc_class_if.source       result,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata
);

    msc_qstat_t qstat;
    msc_entry_t push_entry;
    msc_entry_t head;
    logic       push;
    logic       pop;

    msc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .elem      (elem),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .qstat     (qstat),
        .push      (push),
        .entry     (push_entry)
    );

    msc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    msc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_we (cfg_we),
        .qstat  (qstat),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

    // credits must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (QCNT_W'(qstat.count) + QCNT_W'(push)) <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue overflow");

    // every accepted element reaches the queue on the next cycle
    a_accept_push: assert property (@(posedge clk) disable iff (!rst_n)
        (elem.valid && elem.ready) |=> push)
        else $error("accepted element not pushed");

    // never pop an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("queue underflow");

    // popping the final element of a matrix presents a fresh class
    a_class_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.last) |=> result.valid)
        else $error("class not presented");

endmodule

/* sim/matrix_symmetry_classifier_test.sv */
// Self-checking testbench for the matrix symmetry classifier: directed and random matrices.
module matrix_symmetry_classifier_test;
    import msc_pkg::*;

    localparam int ITEM_TARGET = 1550;
    localparam int QUIET_TAIL  = 200;
    localparam int DRAIN_WAIT  = 8;
    localparam int CYCLE_LIMIT = 300000;

    typedef enum int {
        SHAPE_SYM,
        SHAPE_SKEW,
        SHAPE_SYM_BROKEN,
        SHAPE_SKEW_BROKEN,
        SHAPE_EDGE_PAIRS,
        SHAPE_NOISE
    } shape_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [SIZE_W-1:0] cfg_wdata;

    msc_elem_if  elem_bus ();
    msc_class_if class_bus ();

    matrix_symmetry_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .elem      (elem_bus),
        .result    (class_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // elements waiting to be sent, classes waiting to be received
    logic [ELEM_W-1:0]  pending_elems[$];
    logic [CLASS_W-1:0] expected_classes[$];

    // shadow of the block's state
    logic [ELEM_W-1:0] element_copy [MAX_DIM*MAX_DIM];
    logic [SIZE_W-1:0] size_reg;
    int unsigned       row_pos;
    int unsigned       col_pos;
    bit                sym_ok;
    bit                skew_ok;

    int          idle_pct;
    int unsigned send_hold;
    int unsigned take_hold;
    int          error_count;
    int          items_queued;
    int          cycle_count;

    function automatic void restart_matrix();
        row_pos = 0;
        col_pos = 0;
        sym_ok  = 1'b1;
        skew_ok = 1'b1;
    endfunction

    function automatic int unsigned active_dim();
        if (size_reg == 0)
            return 1;
        if (size_reg > MAX_DIM)
            return MAX_DIM;
        return 32'(size_reg);
    endfunction

    // update the shadow state with one accepted element; queue a class on the last one
    function automatic void classify_element(input logic [ELEM_W-1:0] v);
        int unsigned       n;
        logic [ELEM_W-1:0] mirror;
        logic [ELEM_W-1:0] neg_mirror;
        n = active_dim();
        element_copy[row_pos*MAX_DIM + col_pos] = v;
        if (col_pos < row_pos)
        begin
            mirror     = element_copy[col_pos*MAX_DIM + row_pos];
            neg_mirror = -mirror;
            if (v != mirror)
                sym_ok = 1'b0;
            if (v != neg_mirror)
                skew_ok = 1'b0;
        end
        else if (col_pos == row_pos && v != '0)
            skew_ok = 1'b0;

        if (col_pos + 1 < n)
            col_pos++;
        else if (row_pos + 1 < n)
        begin
            col_pos = 0;
            row_pos++;
        end
        else
        begin
            if (sym_ok)
                expected_classes.push_back(CLASS_SYM);
            else if (skew_ok)
                expected_classes.push_back(CLASS_SKEW);
            else
                expected_classes.push_back(CLASS_NONE);
            restart_matrix();
        end
    endfunction

    function automatic logic [ELEM_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_word(input logic [ELEM_W-1:0] v);
        pending_elems.push_back(v);
        items_queued++;
    endtask

    task automatic queue_matrix(input int unsigned n);
        logic [ELEM_W-1:0] m [MAX_DIM][MAX_DIM];
        shape_t            shape;
        int unsigned       r;
        int unsigned       c;
        shape = shape_t'($urandom_range(0, 5));
        for (r = 0; r < n; r++)
            for (c = 0; c < n; c++)
                m[r][c] = (shape == SHAPE_EDGE_PAIRS) ?
                          ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h0) : random_word();
        for (r = 0; r < n; r++)
        begin
            for (c = 0; c < r; c++)
            begin
                if (shape == SHAPE_SYM || shape == SHAPE_SYM_BROKEN)
                    m[r][c] = m[c][r];
                else if (shape != SHAPE_NOISE)
                    m[r][c] = -m[c][r];
            end
            if (shape == SHAPE_SKEW || shape == SHAPE_SKEW_BROKEN || shape == SHAPE_EDGE_PAIRS)
                m[r][r] = '0;
        end
        if (shape == SHAPE_SYM_BROKEN && n > 1)
        begin
            r = $urandom_range(1, n - 1);
            c = $urandom_range(0, r - 1);
            m[r][c] ^= 32'h1 << $urandom_range(0, 31);
        end
        else if (shape == SHAPE_SKEW_BROKEN)
        begin
            // may hit the diagonal
            r = $urandom_range(0, n - 1);
            c = $urandom_range(0, r);
            m[r][c] ^= 32'h1 << $urandom_range(0, 31);
        end
        for (r = 0; r < n; r++)
            for (c = 0; c < n; c++)
                queue_word(m[r][c]);
    endtask

    // block idle: everything sent, every class received, pipeline flushed
    task automatic wait_drained();
        while (pending_elems.size() != 0 || elem_bus.valid || expected_classes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] v);
        wait_drained();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        size_reg = v;
        restart_matrix();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        clk                       = 1'b0;
        rst_n                     = 1'b0;
        elem_bus.valid            = 1'b0;
        elem_bus.element_value    = '0;
        class_bus.ready           = 1'b0;
        forever #2 clk = ~clk;
    end

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_bus.valid         <= 1'b0;
            elem_bus.element_value <= '0;
            send_hold              <= 0;
        end
        else
        begin
            if (elem_bus.valid && elem_bus.ready)
                classify_element(elem_bus.element_value);
            if (!elem_bus.valid || elem_bus.ready)
            begin
                if (send_hold != 0)
                begin
                    send_hold      <= send_hold - 1;
                    elem_bus.valid <= 1'b0;
                end
                else if (pending_elems.size() == 0)
                    elem_bus.valid <= 1'b0;
                else if ($urandom_range(0, 99) < idle_pct)
                begin
                    send_hold      <= $urandom_range(0, 13);
                    elem_bus.valid <= 1'b0;
                end
                else
                begin
                    elem_bus.valid         <= 1'b1;
                    elem_bus.element_value <= pending_elems.pop_front();
                end
            end
        end
    end

    // receiver and class check
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_bus.ready <= 1'b0;
            take_hold       <= 0;
        end
        else
        begin
            if (class_bus.valid && class_bus.ready)
            begin
                if (expected_classes.size() == 0)
                begin
                    $error("matrix_class: unexpected transaction, actual %0d",
                           class_bus.matrix_class);
                    error_count++;
                end
                else
                begin
                    if (class_bus.matrix_class !== expected_classes[0])
                    begin
                        $error("matrix_class expected %0d actual %0d",
                               expected_classes[0], class_bus.matrix_class);
                        error_count++;
                    end
                    void'(expected_classes.pop_front());
                end
            end
            if (take_hold != 0)
            begin
                take_hold       <= take_hold - 1;
                class_bus.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < idle_pct)
            begin
                take_hold       <= $urandom_range(0, 13);
                class_bus.ready <= 1'b0;
            end
            else
                class_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int          phase;
        int          n_mats;
        int          k;
        int unsigned dim;
        logic [SIZE_W-1:0] code;

        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        cycle_count  = 0;
        error_count  = 0;
        items_queued = 0;
        idle_pct     = 20;
        size_reg     = SIZE_W'(4);
        restart_matrix();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // size left at its reset value
        queue_matrix(4);

        // single element: always symmetric
        write_size(SIZE_W'(1));
        @(negedge clk);
        queue_word(32'h8000_0000);
        queue_word(32'h7FFF_FFFF);

        write_size(SIZE_W'(2));
        @(negedge clk);
        queue_word(32'h0);          queue_word(32'h5);
        queue_word(32'hFFFF_FFFB);  queue_word(32'h0);
        // most negative value on the diagonal breaks skew symmetry
        queue_word(32'h8000_0000);  queue_word(32'h1);
        queue_word(32'hFFFF_FFFF);  queue_word(32'h0);
        // symmetric and skew at once: symmetric wins
        queue_word(32'h0);          queue_word(32'h8000_0000);
        queue_word(32'h8000_0000);  queue_word(32'h0);
        queue_word(32'h0);          queue_word(32'h7FFF_FFFF);
        queue_word(32'h8000_0001);  queue_word(32'h0);
        queue_word(32'h1);          queue_word(32'h2);
        queue_word(32'h3);          queue_word(32'h4);

        // partial matrix dropped by a size write; size zero acts as one
        write_size(SIZE_W'(3));
        @(negedge clk);
        queue_word(32'h1);
        queue_word(32'h2);
        queue_word(32'h3);
        queue_word(32'h4);
        write_size(SIZE_W'(0));
        @(negedge clk);
        queue_word(32'hFFFF_FFFF);

        phase = 0;
        while (items_queued < ITEM_TARGET)
        begin
            phase++;
            if (phase == 1)
                code = SIZE_W'(MAX_DIM);
            else if (phase == 2)
                code = SIZE_W'(31);
            else
            begin
                case ($urandom_range(0, 29))
                    0:       code = SIZE_W'(0);
                    1, 2:    code = SIZE_W'(1);
                    3:       code = SIZE_W'(MAX_DIM);
                    4:       code = SIZE_W'($urandom_range(MAX_DIM + 1, 31));
                    default: code = SIZE_W'($urandom_range(2, 7));
                endcase
            end
            write_size(code);
            @(negedge clk);
            if (items_queued >= ITEM_TARGET - QUIET_TAIL)
                idle_pct = 0;
            else
            begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 10;
                    default: idle_pct = 35;
                endcase
            end
            dim    = (code == 0) ? 32'd1 : (code > MAX_DIM) ? 32'(MAX_DIM) : 32'(code);
            n_mats = (dim >= MAX_DIM) ? 1 : $urandom_range(2, 8);
            for (k = 0; k < n_mats; k++)
                queue_matrix(dim);
            // now and then an unfinished matrix, dropped by the next size write
            if (dim > 1 && idle_pct != 0 && $urandom_range(0, 5) == 0)
            begin
                k = $urandom_range(1, dim * dim - 1);
                repeat (k) queue_word(random_word());
            end
        end

        wait_drained();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
